@@ rtl/core/wheel_encoder_delta_core_macros.svh @@
// assertion macros for the wheel encoder delta checker
`ifndef WHEEL_ENCODER_DELTA_CORE_MACROS_SVH
`define WHEEL_ENCODER_DELTA_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define WED_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define WED_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/wed_pkg.sv @@
// shared types, constants and the frame unpack function of the wheel encoder delta core
package wed_pkg;

    localparam int POSITION_BITS_DEF = 9;
    localparam int WORD_POS_W        = 9;
    localparam int RAW_W             = 16;
    localparam int STAMP_W           = 16;
    localparam int ELAPSED_W         = 17;
    localparam int DELTA_W           = 10;
    localparam int CFG_W             = 9;
    localparam int CFG_IDX_W         = 2;

    localparam logic [RAW_W-1:0] FRAME_ZERO_MASK = 16'h0078;
    localparam logic [RAW_W-1:0] FRAME_ONE_MASK  = 16'hC080;
    localparam logic [RAW_W-1:0] LOW_POS_MASK    = 16'h0007;
    localparam logic [RAW_W-1:0] HIGH_POS_MASK   = 16'h3F00;

    localparam logic [CFG_W-1:0]     MAX_STEP_RST  = 9'd100;
    localparam logic [CFG_W-1:0]     WRAP_SPAN_RST = 9'd511;
    localparam logic [ELAPSED_W-1:0] ELAPSED_FULL  = 17'h10000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_STEP,
        REG_WRAP_SPAN,
        REG_LEFT_REVERSE,
        REG_RIGHT_REVERSE
    } t_reg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] max_step;
        logic [CFG_W-1:0] wrap_span;
        logic             left_reverse;
        logic             right_reverse;
    } t_cfg;

    // frame check and bit gather; a bad frame gives position 0
    function automatic logic [WORD_POS_W-1:0] unpack_word(input logic [RAW_W-1:0] w);
        logic [RAW_W-1:0] gathered;
        gathered = (w & LOW_POS_MASK) | ((w & HIGH_POS_MASK) >> 5);
        if (((w & FRAME_ZERO_MASK) != '0) || ((w & FRAME_ONE_MASK) != FRAME_ONE_MASK)) begin
            return '0;
        end
        return gathered[WORD_POS_W-1:0];
    endfunction

endpackage

@@ rtl/core/wed_ifs.sv @@
// sample, result and configuration channel interfaces
interface wed_in_if import wed_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] cur_left_raw;
    logic [RAW_W-1:0] cur_right_raw;
    logic [STAMP_W-1:0] cur_stamp;
    logic [RAW_W-1:0] prev_left_raw;
    logic [RAW_W-1:0] prev_right_raw;
    logic [STAMP_W-1:0] prev_stamp;

    modport source (
        output valid, cur_left_raw, cur_right_raw, cur_stamp,
               prev_left_raw, prev_right_raw, prev_stamp,
        input  ready
    );
    modport sink (
        input  valid, cur_left_raw, cur_right_raw, cur_stamp,
               prev_left_raw, prev_right_raw, prev_stamp,
        output ready
    );
endinterface

interface wed_out_if import wed_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [DELTA_W-1:0]  left_delta;
    logic signed [DELTA_W-1:0]  right_delta;
    logic [ELAPSED_W-1:0]       elapsed_ms;

    modport source (output valid, left_delta, right_delta, elapsed_ms, input ready);
    modport sink (input valid, left_delta, right_delta, elapsed_ms, output ready);
endinterface

interface wed_cfg_if import wed_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/wheel_encoder_delta_core.sv @@
// top level of the wheel encoder delta core
// Takes one sample pair per clock and returns left and right position
// deltas plus the elapsed stamp time through three register stages
// (unpack, difference, select); a sustained rate of one item per cycle
// holds while the sink keeps ready high. A stall on the output backs up
// stage by stage through a combinational ready chain, so each stage
// still fills while a finished result waits. Configuration writes
// are taken every cycle and act at once on the difference and select
// stages, so items already in flight would see them; write registers only
// while no request is in flight.
module wheel_encoder_delta_core import wed_pkg::*; #(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wed_cfg_if.sink    i_cfg,
    wed_in_if.sink     i_in,
    wed_out_if.source  o_out
);

    localparam int POS_W = (POSITION_BITS < WORD_POS_W) ? POSITION_BITS : WORD_POS_W;

    t_cfg w_cfg;

    logic                  w_s1_valid;
    logic                  w_s2_ready;
    logic [POS_W-1:0]      w_cur_left;
    logic [POS_W-1:0]      w_prev_left;
    logic [POS_W-1:0]      w_cur_right;
    logic [POS_W-1:0]      w_prev_right;
    logic [ELAPSED_W-1:0]  w_s1_elapsed;

    logic                  w_s2_valid;
    logic                  w_s3_ready;
    logic signed [POS_W:0] w_left_d;
    logic [POS_W-1:0]      w_left_a;
    logic signed [POS_W:0] w_right_d;
    logic [POS_W-1:0]      w_right_a;
    logic [ELAPSED_W-1:0]  w_s2_elapsed;

    wed_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    wed_unpack #(.POS_W(POS_W)) u_unpack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_valid      (w_s1_valid),
        .i_ready      (w_s2_ready),
        .o_cur_left   (w_cur_left),
        .o_prev_left  (w_prev_left),
        .o_cur_right  (w_cur_right),
        .o_prev_right (w_prev_right),
        .o_elapsed    (w_s1_elapsed)
    );

    wed_diff #(.POS_W(POS_W)) u_diff (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_valid      (w_s1_valid),
        .o_ready      (w_s2_ready),
        .i_cur_left   (w_cur_left),
        .i_prev_left  (w_prev_left),
        .i_cur_right  (w_cur_right),
        .i_prev_right (w_prev_right),
        .i_elapsed    (w_s1_elapsed),
        .o_valid      (w_s2_valid),
        .i_ready      (w_s3_ready),
        .o_left_d     (w_left_d),
        .o_left_a     (w_left_a),
        .o_right_d    (w_right_d),
        .o_right_a    (w_right_a),
        .o_elapsed    (w_s2_elapsed)
    );

    wed_select #(.POS_W(POS_W)) u_select (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_valid   (w_s2_valid),
        .o_ready   (w_s3_ready),
        .i_left_d  (w_left_d),
        .i_left_a  (w_left_a),
        .i_right_d (w_right_d),
        .i_right_a (w_right_a),
        .i_elapsed (w_s2_elapsed),
        .o_out     (o_out)
    );

endmodule

@@ rtl/core/wed_cfg_regs.sv @@
// configuration register file
module wed_cfg_regs import wed_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wed_cfg_if.sink    i_cfg,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_MAX_STEP:      n_cfg.max_step      = i_cfg.data;
                REG_WRAP_SPAN:     n_cfg.wrap_span     = i_cfg.data;
                REG_LEFT_REVERSE:  n_cfg.left_reverse  = i_cfg.data[0];
                REG_RIGHT_REVERSE: n_cfg.right_reverse = i_cfg.data[0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_step      <= MAX_STEP_RST;
            r_cfg.wrap_span     <= WRAP_SPAN_RST;
            r_cfg.left_reverse  <= 1'b0;
            r_cfg.right_reverse <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

@@ rtl/core/wed_unpack.sv @@
// stage 1: frame check and unpack of all four words, stamp difference
module wed_unpack import wed_pkg::*; #(
    parameter int POS_W = WORD_POS_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    wed_in_if.sink                i_in,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [POS_W-1:0]      o_cur_left,
    output logic [POS_W-1:0]      o_prev_left,
    output logic [POS_W-1:0]      o_cur_right,
    output logic [POS_W-1:0]      o_prev_right,
    output logic [ELAPSED_W-1:0]  o_elapsed
);

    logic                 r_valid;
    logic [POS_W-1:0]     r_cur_left;
    logic [POS_W-1:0]     r_prev_left;
    logic [POS_W-1:0]     r_cur_right;
    logic [POS_W-1:0]     r_prev_right;
    logic [ELAPSED_W-1:0] r_elapsed;

    logic                 w_load;
    logic [STAMP_W-1:0]   w_stamp_diff;
    logic [ELAPSED_W-1:0] n_elapsed;
    logic [WORD_POS_W-1:0] w_cl;
    logic [WORD_POS_W-1:0] w_pl;
    logic [WORD_POS_W-1:0] w_cr;
    logic [WORD_POS_W-1:0] w_pr;

    assign i_in.ready = !r_valid || i_ready;
    assign w_load     = i_in.ready;

    assign w_cl = unpack_word(i_in.cur_left_raw);
    assign w_pl = unpack_word(i_in.prev_left_raw);
    assign w_cr = unpack_word(i_in.cur_right_raw);
    assign w_pr = unpack_word(i_in.prev_right_raw);

    // equal stamps mean a full wrap of the counter
    assign w_stamp_diff = i_in.cur_stamp - i_in.prev_stamp;
    assign n_elapsed    = (w_stamp_diff == '0) ? ELAPSED_FULL : {1'b0, w_stamp_diff};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_in.valid) begin
            r_cur_left   <= w_cl[POS_W-1:0];
            r_prev_left  <= w_pl[POS_W-1:0];
            r_cur_right  <= w_cr[POS_W-1:0];
            r_prev_right <= w_pr[POS_W-1:0];
            r_elapsed    <= n_elapsed;
        end
    end

    assign o_valid      = r_valid;
    assign o_cur_left   = r_cur_left;
    assign o_prev_left  = r_prev_left;
    assign o_cur_right  = r_cur_right;
    assign o_prev_right = r_prev_right;
    assign o_elapsed    = r_elapsed;

endmodule

@@ rtl/core/wed_diff.sv @@
// stage 2: direction-signed position difference and its magnitude per wheel
module wed_diff import wed_pkg::*; #(
    parameter int POS_W = WORD_POS_W
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cfg                     i_cfg,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [POS_W-1:0]         i_cur_left,
    input  logic [POS_W-1:0]         i_prev_left,
    input  logic [POS_W-1:0]         i_cur_right,
    input  logic [POS_W-1:0]         i_prev_right,
    input  logic [ELAPSED_W-1:0]     i_elapsed,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [POS_W:0]    o_left_d,
    output logic [POS_W-1:0]         o_left_a,
    output logic signed [POS_W:0]    o_right_d,
    output logic [POS_W-1:0]         o_right_a,
    output logic [ELAPSED_W-1:0]     o_elapsed
);

    logic                  r_valid;
    logic signed [POS_W:0] r_left_d;
    logic [POS_W-1:0]      r_left_a;
    logic signed [POS_W:0] r_right_d;
    logic [POS_W-1:0]      r_right_a;
    logic [ELAPSED_W-1:0]  r_elapsed;

    logic signed [POS_W:0] n_left_d;
    logic signed [POS_W:0] n_right_d;
    logic signed [POS_W:0] w_left_abs;
    logic signed [POS_W:0] w_right_abs;

    assign o_ready = !r_valid || i_ready;

    assign n_left_d = i_cfg.left_reverse
        ? $signed({1'b0, i_prev_left}) - $signed({1'b0, i_cur_left})
        : $signed({1'b0, i_cur_left}) - $signed({1'b0, i_prev_left});
    assign n_right_d = i_cfg.right_reverse
        ? $signed({1'b0, i_prev_right}) - $signed({1'b0, i_cur_right})
        : $signed({1'b0, i_cur_right}) - $signed({1'b0, i_prev_right});

    // magnitude never exceeds the position range, so it fits POS_W bits
    assign w_left_abs  = (n_left_d < 0) ? -n_left_d : n_left_d;
    assign w_right_abs = (n_right_d < 0) ? -n_right_d : n_right_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_left_d  <= n_left_d;
            r_left_a  <= w_left_abs[POS_W-1:0];
            r_right_d <= n_right_d;
            r_right_a <= w_right_abs[POS_W-1:0];
            r_elapsed <= i_elapsed;
        end
    end

    assign o_valid   = r_valid;
    assign o_left_d  = r_left_d;
    assign o_left_a  = r_left_a;
    assign o_right_d = r_right_d;
    assign o_right_a = r_right_a;
    assign o_elapsed = r_elapsed;

endmodule

@@ rtl/core/wed_select.sv @@
// stage 3: small step, rollover unwrap or large jump select, output register
module wed_select import wed_pkg::*; #(
    parameter int POS_W = WORD_POS_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic signed [POS_W:0] i_left_d,
    input  logic [POS_W-1:0]      i_left_a,
    input  logic signed [POS_W:0] i_right_d,
    input  logic [POS_W-1:0]      i_right_a,
    input  logic [ELAPSED_W-1:0]  i_elapsed,
    wed_out_if.source             o_out
);

    localparam int WIDE_W = DELTA_W + 1;

    logic                      r_valid;
    logic signed [DELTA_W-1:0] r_left_delta;
    logic signed [DELTA_W-1:0] r_right_delta;
    logic [ELAPSED_W-1:0]      r_elapsed;

    logic signed [WIDE_W-1:0]  n_left;
    logic signed [WIDE_W-1:0]  n_right;

    function automatic logic signed [WIDE_W-1:0] pick(
        input logic signed [POS_W:0] d,
        input logic [POS_W-1:0]      a,
        input logic [CFG_W-1:0]      lim,
        input logic [CFG_W-1:0]      span
    );
        logic [CFG_W-1:0]         a9;
        logic signed [CFG_W:0]    gap;
        logic signed [CFG_W:0]    gap_abs;
        logic signed [WIDE_W-1:0] dw;
        logic signed [WIDE_W-1:0] sw;
        a9      = CFG_W'(a);
        gap     = $signed({1'b0, span}) - $signed({1'b0, a9});
        gap_abs = (gap < 0) ? -gap : gap;
        dw      = WIDE_W'(d);
        sw      = $signed(WIDE_W'(span));
        if (a9 <= lim) begin
            return dw;
        end
        // near a full span: treat as rollover and unwrap
        if (gap_abs <= $signed({1'b0, lim})) begin
            return (dw >= 0) ? dw - sw : dw + sw;
        end
        return '0;
    endfunction

    assign o_ready = !r_valid || o_out.ready;

    assign n_left  = pick(i_left_d, i_left_a, i_cfg.max_step, i_cfg.wrap_span);
    assign n_right = pick(i_right_d, i_right_a, i_cfg.max_step, i_cfg.wrap_span);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_left_delta  <= n_left[DELTA_W-1:0];
            r_right_delta <= n_right[DELTA_W-1:0];
            r_elapsed     <= i_elapsed;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.left_delta  = r_left_delta;
    assign o_out.right_delta = r_right_delta;
    assign o_out.elapsed_ms  = r_elapsed;

endmodule

@@ rtl/core/wed_checker.sv @@
// port-level checker for the wheel encoder delta core, with its bind
`include "wheel_encoder_delta_core_macros.svh"

module wed_checker import wed_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [DELTA_W-1:0]   i_left_delta,
    input logic [DELTA_W-1:0]   i_right_delta,
    input logic [ELAPSED_W-1:0] i_elapsed_ms
);

    // a stalled result keeps its value
    `WED_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_left_delta) && $stable(i_right_delta) && $stable(i_elapsed_ms), "result changed while stalled")

    // elapsed time lies in 1..65536
    `WED_ASSERT_HOLDS(a_elapsed_range, i_clk, i_rst_n, i_out_valid, (i_elapsed_ms != '0) && (!i_elapsed_ms[16] || (i_elapsed_ms[15:0] == 16'h0000)), "elapsed time out of range")

    // deltas stay within +-511
    `WED_ASSERT_HOLDS(a_left_range, i_clk, i_rst_n, i_out_valid, i_left_delta != 10'h200, "left delta out of range")
    `WED_ASSERT_HOLDS(a_right_range, i_clk, i_rst_n, i_out_valid, i_right_delta != 10'h200, "right delta out of range")

endmodule

bind wheel_encoder_delta_core wed_checker u_wed_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_left_delta  (o_out.left_delta),
    .i_right_delta (o_out.right_delta),
    .i_elapsed_ms  (o_out.elapsed_ms)
);
